// ===== rtl/clns_pkg.sv =====
`default_nettype none
package clns_pkg;

	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth  = 16;
	localparam int unsigned StepWidth     = 4;

	localparam logic [9:0]  PulseLengthReset   = 10'd10;
	localparam logic [9:0]  SettleTimeReset    = 10'd150;
	localparam logic [15:0] PowerUpWaitReset   = 16'd40000;
	localparam logic [15:0] InitWaitLongReset  = 16'd5000;
	localparam logic [9:0]  InitWaitShortReset = 10'd150;
	localparam logic [15:0] SlowCmdWaitReset   = 16'd2000;

	localparam logic [7:0] CmdFuncSet = 8'h28;
	localparam logic [7:0] CmdDispOn  = 8'h0E;
	localparam logic [7:0] CmdClear   = 8'h01;
	localparam logic [7:0] CmdHome    = 8'h02;
	localparam logic [7:0] CmdEntry   = 8'h06;
	localparam logic [7:0] AddrRow1   = 8'h80;
	localparam logic [7:0] AddrRow2   = 8'hC0;
	localparam logic [3:0] InitNibble = 4'h3;
	localparam logic [3:0] Mode4Bit   = 4'h2;

	localparam logic [StepWidth-1:0] ByteLastStep = 4'd1;
	localparam logic [StepWidth-1:0] InitLastStep = 4'd11;

	typedef enum logic [2:0] {
		MODE_COMMAND = 3'd0,
		MODE_DATA    = 3'd1,
		MODE_CURSOR  = 3'd2,
		MODE_CLEAR   = 3'd3,
		MODE_HOME    = 3'd4,
		MODE_INIT    = 3'd5
	} mode_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_PULSE_LENGTH    = 3'd0,
		REG_SETTLE_TIME     = 3'd1,
		REG_POWER_UP_WAIT   = 3'd2,
		REG_INIT_WAIT_LONG  = 3'd3,
		REG_INIT_WAIT_SHORT = 3'd4,
		REG_SLOW_CMD_WAIT   = 3'd5
	} reg_index_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		EXTRA_NONE,
		EXTRA_LONG,
		EXTRA_SHORT,
		EXTRA_SLOW
	} extra_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [4:0] column;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_before;
		logic [9:0]  enable_ticks;
		logic [16:0] wait_after;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [9:0]  pulse_length;
		logic [9:0]  settle_time;
		logic [15:0] power_up_wait;
		logic [15:0] init_wait_long;
		logic [9:0]  init_wait_short;
		logic [15:0] slow_cmd_wait;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       reg_select;
		logic [3:0] nibble;
		extra_t     extra;
		logic       power_up;
		logic       last;
	} step_t;

	function automatic step_t init_step(input logic [StepWidth-1:0] idx);
		step_t s;
		s.valid      = 1'b1;
		s.reg_select = 1'b0;
		s.nibble     = InitNibble;
		s.extra      = EXTRA_NONE;
		s.power_up   = 1'b0;
		s.last       = 1'b0;
		case (idx)
			4'd0: begin
				s.power_up = 1'b1;
				s.extra    = EXTRA_LONG;
			end
			4'd1: s.extra = EXTRA_SHORT;
			4'd2: s.nibble = InitNibble;
			4'd3: s.nibble = Mode4Bit;
			4'd4: s.nibble = CmdFuncSet[7:4];
			4'd5: s.nibble = CmdFuncSet[3:0];
			4'd6: s.nibble = CmdDispOn[7:4];
			4'd7: s.nibble = CmdDispOn[3:0];
			4'd8: s.nibble = CmdClear[7:4];
			4'd9: begin
				s.nibble = CmdClear[3:0];
				s.extra  = EXTRA_SLOW;
			end
			4'd10: s.nibble = CmdEntry[7:4];
			4'd11: begin
				s.nibble = CmdEntry[3:0];
				s.last   = 1'b1;
			end
			default: s.valid = 1'b0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Channel    Handshake                   Payload
// request    start, busy                 req (clns_pkg::req_t)
// result     result_strobe               result (clns_pkg::rsp_t)
// config     cfg_we                      cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. Its first nibble
// transfer passes the sequencer state/step registers and the result register,
// then one per cycle from the step counter: 2 for a byte request, 12 for init.
// A request that yields no transfer (bad row, unused mode) leaves busy low.
// Reset clears the registers to their defaults and the sequencer to idle.
// Results are shown for one cycle each; the receiver cannot stall them.
`default_nettype none
module char_lcd_nibble_sequencer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire clns_pkg::req_t                       req,
	output logic                                      result_strobe,
	output clns_pkg::rsp_t                            result,
	input  wire logic                                 cfg_we,
	input  wire logic [clns_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [clns_pkg::CfgDataWidth-1:0]    cfg_data
);

	clns_pkg::cfg_t  cfg;
	clns_pkg::step_t step;
	logic            run;

	clns_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clns_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.run    (run),
		.step   (step)
	);

	clns_xfer_unit u_xfer_unit (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cfg           (cfg),
		.result_strobe (result_strobe),
		.result        (result)
	);

	assign busy = run;

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_strobe)
		else $error("transfer appeared in the cycle right after a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |=> !result_strobe)
		else $error("transfer followed the final transfer of a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (result.wait_before != 16'd0)) |->
		((result.nibble == clns_pkg::InitNibble) && !result.last && !result.reg_select))
		else $error("power-up wait on a transfer other than the first init nibble");

endmodule
`default_nettype wire

// ===== rtl/clns_cfg_regs.sv =====
`default_nettype none
module clns_cfg_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [clns_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [clns_pkg::CfgDataWidth-1:0]    cfg_data,
	output clns_pkg::cfg_t                            cfg
);

	clns_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_length    <= clns_pkg::PulseLengthReset;
			cfg_q.settle_time     <= clns_pkg::SettleTimeReset;
			cfg_q.power_up_wait   <= clns_pkg::PowerUpWaitReset;
			cfg_q.init_wait_long  <= clns_pkg::InitWaitLongReset;
			cfg_q.init_wait_short <= clns_pkg::InitWaitShortReset;
			cfg_q.slow_cmd_wait   <= clns_pkg::SlowCmdWaitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				clns_pkg::REG_PULSE_LENGTH:    cfg_q.pulse_length    <= cfg_data[9:0];
				clns_pkg::REG_SETTLE_TIME:     cfg_q.settle_time     <= cfg_data[9:0];
				clns_pkg::REG_POWER_UP_WAIT:   cfg_q.power_up_wait   <= cfg_data;
				clns_pkg::REG_INIT_WAIT_LONG:  cfg_q.init_wait_long  <= cfg_data;
				clns_pkg::REG_INIT_WAIT_SHORT: cfg_q.init_wait_short <= cfg_data[9:0];
				clns_pkg::REG_SLOW_CMD_WAIT:   cfg_q.slow_cmd_wait   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/clns_sequencer.sv =====
`default_nettype none
module clns_sequencer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire clns_pkg::req_t req,
	output logic                run,
	output clns_pkg::step_t     step
);

	clns_pkg::state_t state_q, state_d;
	logic [clns_pkg::StepWidth-1:0] step_q;
	logic [clns_pkg::StepWidth-1:0] last_step_q;
	logic [7:0] byte_q;
	logic       rs_q;
	logic       slow_q;
	logic       init_q;

	logic       accept;
	logic       req_ok;
	logic [7:0] req_byte;
	logic       req_rs;
	logic       req_slow;
	logic       req_init;
	logic [7:0] cursor_addr;
	logic       step_done;

	assign accept      = start && (state_q == clns_pkg::ST_IDLE);
	assign cursor_addr = {3'b000, req.column} - 8'd1;
	assign step_done   = (step_q == last_step_q);

	always_comb begin
		req_ok   = 1'b1;
		req_byte = req.byte_value;
		req_rs   = 1'b0;
		req_slow = 1'b0;
		req_init = 1'b0;
		case (req.mode)
			clns_pkg::MODE_COMMAND: req_byte = req.byte_value;
			clns_pkg::MODE_DATA:    req_rs   = 1'b1;
			clns_pkg::MODE_CURSOR: begin
				if (req.row == 2'd1) begin
					req_byte = cursor_addr | clns_pkg::AddrRow1;
				end else if (req.row == 2'd2) begin
					req_byte = cursor_addr | clns_pkg::AddrRow2;
				end else begin
					req_ok = 1'b0;
				end
			end
			clns_pkg::MODE_CLEAR: begin
				req_byte = clns_pkg::CmdClear;
				req_slow = 1'b1;
			end
			clns_pkg::MODE_HOME: begin
				req_byte = clns_pkg::CmdHome;
				req_slow = 1'b1;
			end
			clns_pkg::MODE_INIT: req_init = 1'b1;
			default: req_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			clns_pkg::ST_IDLE: if (accept && req_ok) state_d = clns_pkg::ST_RUN;
			clns_pkg::ST_RUN:  if (step_done) state_d = clns_pkg::ST_IDLE;
			default: state_d = clns_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clns_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == clns_pkg::ST_RUN) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q      <= req_byte;
			rs_q        <= req_rs;
			slow_q      <= req_slow;
			init_q      <= req_init;
			last_step_q <= req_init ? clns_pkg::InitLastStep : clns_pkg::ByteLastStep;
		end
	end

	always_comb begin
		run = (state_q == clns_pkg::ST_RUN);
		if (init_q) begin
			step = clns_pkg::init_step(step_q);
		end else begin
			step.valid      = 1'b1;
			step.reg_select = rs_q;
			step.nibble     = step_q[0] ? byte_q[3:0] : byte_q[7:4];
			step.extra      = (step_q[0] && slow_q) ? clns_pkg::EXTRA_SLOW
				: clns_pkg::EXTRA_NONE;
			step.power_up   = 1'b0;
			step.last       = step_q[0];
		end
		step.valid = step.valid && run;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clns_pkg::ST_RUN) |-> (step_q <= last_step_q))
		else $error("step counter ran past the end of the request");

endmodule
`default_nettype wire

// ===== rtl/clns_xfer_unit.sv =====
`default_nettype none
module clns_xfer_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire clns_pkg::step_t step,
	input  wire clns_pkg::cfg_t  cfg,
	output logic                 result_strobe,
	output clns_pkg::rsp_t       result
);

	logic [15:0]    extra;
	logic [16:0]    wait_sum;
	logic           strobe_q;
	clns_pkg::rsp_t result_q;

	always_comb begin
		case (step.extra)
			clns_pkg::EXTRA_NONE:  extra = '0;
			clns_pkg::EXTRA_LONG:  extra = cfg.init_wait_long;
			clns_pkg::EXTRA_SHORT: extra = {6'd0, cfg.init_wait_short};
			clns_pkg::EXTRA_SLOW:  extra = cfg.slow_cmd_wait;
			default:               extra = '0;
		endcase
	end

	assign wait_sum = {7'd0, cfg.settle_time} + {1'b0, extra};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid) begin
			result_q.reg_select   <= step.reg_select;
			result_q.nibble       <= step.nibble;
			result_q.wait_before  <= step.power_up ? cfg.power_up_wait : 16'd0;
			result_q.enable_ticks <= cfg.pulse_length;
			result_q.wait_after   <= wait_sum;
			result_q.last         <= step.last;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule
`default_nettype wire

// ===== tb/sv/char_lcd_nibble_sequencer_check.sv =====
module char_lcd_nibble_sequencer_check
	import clns_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  req_t                          req,
	input  wire logic                     result_strobe,
	input  rsp_t                          result,
	input  wire logic                     cfg_we,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data,
	output int unsigned                   mismatch_count,
	output int unsigned                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] RowTop = 2'd1;
	localparam logic [1:0] RowBottom = 2'd2;
	localparam int unsigned PrintLimit = 100;

	cfg_t shadow;
	rsp_t nibble_q[$];
	int unsigned transfer_index = 0;

	initial begin
		mismatch_count = 0;
		outstanding = 0;
	end

	function automatic cfg_t default_registers();
		cfg_t c;
		c.pulse_length    = PulseLengthReset;
		c.settle_time     = SettleTimeReset;
		c.power_up_wait   = PowerUpWaitReset;
		c.init_wait_long  = InitWaitLongReset;
		c.init_wait_short = InitWaitShortReset;
		c.slow_cmd_wait   = SlowCmdWaitReset;
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PrintLimit) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	task automatic compare_field(input string name, input logic [16:0] got,
			input logic [16:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("transfer %0d %s: got 0x%0h, want 0x%0h",
				transfer_index, name, got, want));
		end
	endtask

	task automatic queue_nibble(input logic rs, input logic [3:0] nib,
			input logic [15:0] lead_wait, input logic [16:0] extra, input logic last);
		rsp_t n;
		n.reg_select   = rs;
		n.nibble       = nib;
		n.wait_before  = lead_wait;
		n.enable_ticks = shadow.pulse_length;
		n.wait_after   = 17'(shadow.settle_time) + extra;
		n.last         = last;
		nibble_q.push_back(n);
	endtask

	task automatic queue_byte(input logic rs, input logic [7:0] b,
			input logic [16:0] extra, input logic last);
		queue_nibble(rs, b[7:4], '0, '0, 1'b0);
		queue_nibble(rs, b[3:0], '0, extra, last);
	endtask

	task automatic expand_request(input req_t r);
		logic [7:0] addr;
		addr = 8'(r.column) - 8'd1;
		case (r.mode)
			MODE_COMMAND: queue_byte(1'b0, r.byte_value, '0, 1'b1);
			MODE_DATA:    queue_byte(1'b1, r.byte_value, '0, 1'b1);
			MODE_CURSOR: begin
				if (r.row == RowTop) begin
					queue_byte(1'b0, addr | AddrRow1, '0, 1'b1);
				end else if (r.row == RowBottom) begin
					queue_byte(1'b0, addr | AddrRow2, '0, 1'b1);
				end
			end
			MODE_CLEAR: queue_byte(1'b0, CmdClear, 17'(shadow.slow_cmd_wait), 1'b1);
			MODE_HOME:  queue_byte(1'b0, CmdHome, 17'(shadow.slow_cmd_wait), 1'b1);
			MODE_INIT: begin
				queue_nibble(1'b0, InitNibble, shadow.power_up_wait,
					17'(shadow.init_wait_long), 1'b0);
				queue_nibble(1'b0, InitNibble, '0, 17'(shadow.init_wait_short), 1'b0);
				queue_nibble(1'b0, InitNibble, '0, '0, 1'b0);
				queue_nibble(1'b0, Mode4Bit, '0, '0, 1'b0);
				queue_byte(1'b0, CmdFuncSet, '0, 1'b0);
				queue_byte(1'b0, CmdDispOn, '0, 1'b0);
				queue_byte(1'b0, CmdClear, 17'(shadow.slow_cmd_wait), 1'b0);
				queue_byte(1'b0, CmdEntry, '0, 1'b1);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			shadow = default_registers();
			nibble_q.delete();
			outstanding <= 0;
		end else begin
			if (result_strobe) begin
				if (nibble_q.size() == 0) begin
					report_mismatch($sformatf("transfer %0d: no transfer expected, got 0x%0h",
						transfer_index, result));
				end else begin
					want = nibble_q.pop_front();
					compare_field("reg_select", result.reg_select, want.reg_select);
					compare_field("nibble", result.nibble, want.nibble);
					compare_field("wait_before", result.wait_before, want.wait_before);
					compare_field("enable_ticks", result.enable_ticks, want.enable_ticks);
					compare_field("wait_after", result.wait_after, want.wait_after);
					compare_field("last", result.last, want.last);
				end
				transfer_index++;
			end
			if (start && !busy) begin
				expand_request(req);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PULSE_LENGTH:    shadow.pulse_length = cfg_data[9:0];
					REG_SETTLE_TIME:     shadow.settle_time = cfg_data[9:0];
					REG_POWER_UP_WAIT:   shadow.power_up_wait = cfg_data;
					REG_INIT_WAIT_LONG:  shadow.init_wait_long = cfg_data;
					REG_INIT_WAIT_SHORT: shadow.init_wait_short = cfg_data[9:0];
					REG_SLOW_CMD_WAIT:   shadow.slow_cmd_wait = cfg_data;
					default: ;
				endcase
			end
			outstanding <= nibble_q.size();
		end
	end

endmodule

// ===== tb/sv/char_lcd_nibble_sequencer_test.sv =====
module char_lcd_nibble_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import clns_pkg::*;

	localparam int unsigned PhaseCount = 4;
	localparam int unsigned ItemsPerPhase = 95;
	localparam int unsigned PressurePoint = 40;
	localparam int unsigned SettleCycles = 4;

	localparam int unsigned ProfileMax = 0;
	localparam int unsigned ProfileZero = 1;
	localparam int unsigned ProfileRandom = 2;
	localparam int unsigned ProfileLow = 3;

	localparam logic [2:0] ModeSpareLo = 3'd6;
	localparam logic [2:0] ModeSpareHi = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic result_strobe;
	rsp_t result;
	logic cfg_we = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0] cfg_data = '0;
	int unsigned mismatch_count;
	int unsigned outstanding;

	int unsigned idle_pct [PhaseCount] = '{0, 66, 0, 31};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	char_lcd_nibble_sequencer i_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.req,
		.result_strobe,
		.result,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	char_lcd_nibble_sequencer_check i_check (
		.clk,
		.arst_n,
		.start,
		.busy,
		.req,
		.result_strobe,
		.result,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.mismatch_count,
		.outstanding
	);

	function automatic req_t make_req(input logic [2:0] mode, input logic [7:0] b,
			input logic [1:0] row, input logic [4:0] col);
		req_t r;
		r.mode       = mode;
		r.byte_value = b;
		r.row        = row;
		r.column     = col;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.byte_value = 8'($urandom);
		r.row = 2'($urandom);
		r.column = 5'($urandom_range(1, 16));
		if (pick < 25) begin
			r.mode = MODE_COMMAND;
		end else if (pick < 45) begin
			r.mode = MODE_DATA;
		end else if (pick < 65) begin
			r.mode = MODE_CURSOR;
			if ($urandom_range(9) != 0) begin
				r.row = 2'($urandom_range(1, 2));
			end
			if ($urandom_range(7) == 0) begin
				r.column = 5'($urandom);
			end
		end else if (pick < 73) begin
			r.mode = MODE_CLEAR;
		end else if (pick < 81) begin
			r.mode = MODE_HOME;
		end else if (pick < 88) begin
			r.mode = MODE_INIT;
		end else begin
			r.mode = 3'($urandom);
			r.column = 5'($urandom);
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap(input int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			req <= req_t'(18'($urandom));
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic load_registers(input int unsigned profile);
		logic [CfgDataWidth-1:0] value;
		for (int i = 0; i < (1 << CfgIndexWidth); i++) begin
			case (profile)
				ProfileMax:  value = '1;
				ProfileZero: value = '0;
				ProfileLow:  value = CfgDataWidth'($urandom_range(1, 3));
				default:     value = CfgDataWidth'($urandom);
			endcase
			if (i > REG_SLOW_CMD_WAIT) begin
				value = CfgDataWidth'($urandom);
			end
			cfg_we <= 1'b1;
			cfg_index <= CfgIndexWidth'(i);
			cfg_data <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("[char_lcd_nibble_sequencer] ERROR");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(MODE_INIT, 8'h00, 2'd0, 5'd0));
		send_request(make_req(MODE_COMMAND, 8'h00, 2'd0, 5'd0));
		send_request(make_req(MODE_COMMAND, 8'hFF, 2'd3, 5'd31));
		send_request(make_req(MODE_DATA, 8'h5A, 2'd1, 5'd10));
		send_request(make_req(MODE_DATA, 8'hA5, 2'd2, 5'd21));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd1, 5'd1));
		send_request(make_req(MODE_CURSOR, 8'hFF, 2'd1, 5'd16));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd2, 5'd1));
		send_request(make_req(MODE_CURSOR, 8'hFF, 2'd2, 5'd16));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd0, 5'd5));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd3, 5'd5));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd1, 5'd0));
		send_request(make_req(MODE_CURSOR, 8'h00, 2'd2, 5'd31));
		send_request(make_req(MODE_CLEAR, 8'hFF, 2'd3, 5'd31));
		send_request(make_req(MODE_HOME, 8'h00, 2'd0, 5'd0));
		send_request(make_req(ModeSpareLo, 8'hFF, 2'd1, 5'd1));
		send_request(make_req(ModeSpareHi, 8'h33, 2'd2, 5'd2));
		send_request(make_req(MODE_INIT, 8'hFF, 2'd3, 5'd31));
		drain();

		for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
			load_registers(phase);
			for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
				idle_gap(idle_pct[phase]);
				send_request(random_req());
				if (i == PressurePoint) begin
					drain();
				end
			end
			drain();
		end

		repeat (4 * SettleCycles) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("[char_lcd_nibble_sequencer] OK");
		end else begin
			$display("[char_lcd_nibble_sequencer] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/clns_pkg.sv
rtl/clns_cfg_regs.sv
rtl/clns_sequencer.sv
rtl/clns_xfer_unit.sv
rtl/char_lcd_nibble_sequencer.sv
tb/sv/char_lcd_nibble_sequencer_check.sv
tb/sv/char_lcd_nibble_sequencer_test.sv
